### design/pop_pkg.sv
// shared constants for the perpendicular offset point block
`default_nettype none
package pop_pkg;
  localparam int COORD_BITS_DEF = 18;
  localparam int DIST_BITS      = 10;
  localparam logic [DIST_BITS-1:0] DIST_RESET = 10'd100;
  // one cell per quotient bit, quotient never exceeds the distance
  localparam int Q_BITS         = DIST_BITS;
  // front end stages ahead of the cell row
  localparam int FRONT_STAGES   = 3;
endpackage
`default_nettype wire

### design/perpendicular_offset_point_top.sv
// top level of the perpendicular offset point block
//
// usage
//   input item: start_x, start_y, end_x, end_y, taken at a rising edge with
//   start high and busy low; busy stays low, so one edge can enter per cycle
//   result item: point_x, point_y, vertical_edge, shown for one cycle with
//   done high; the receiver cannot stall, so nothing is held back
//   config: offset_distance written through cfg_valid / cfg_ready /
//   cfg_data; cfg_ready is always high
// pipeline: 3 front stages, one cell per quotient bit, one output register;
//   throughput one item per cycle, set by the cell row where each cell
//   settles one bit of both quotients
// reset: clears every valid bit in the pipe, drops done and sets the
//   offset distance to 100
// each quotient is found exactly by comparing q^2*(dx^2+dy^2) with
//   (d*|a|)^2, the squares built up incrementally along the row
`default_nettype none
module perpendicular_offset_point_top #(
  parameter int COORD_BITS = pop_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [pop_pkg::DIST_BITS-1:0] cfg_data,
  output logic                              done,
  output logic signed [COORD_BITS:0]        point_x,
  output logic signed [COORD_BITS:0]        point_y,
  output logic                              vertical_edge
);
  localparam int CB = COORD_BITS;
  localparam int QB = pop_pkg::Q_BITS;
  localparam int TW = 2*CB + 2*pop_pkg::DIST_BITS;
  localparam int W  = TW + 1;
  localparam int SW = 2*CB + 3;

  logic [pop_pkg::DIST_BITS-1:0] offset_distance;

  // chain taps between cells, index 0 is the front end output
  logic          cv   [QB+1];
  logic [2*CB:0] cs   [QB+1];
  logic [TW-1:0] ctx  [QB+1];
  logic [TW-1:0] cty  [QB+1];
  logic [W-1:0]  cq2x [QB+1];
  logic [W-1:0]  cqsx [QB+1];
  logic [QB-1:0] cqx  [QB+1];
  logic [W-1:0]  cq2y [QB+1];
  logic [W-1:0]  cqsy [QB+1];
  logic [QB-1:0] cqy  [QB+1];
  logic [SW-1:0] cside[QB+1];

  // finishing stage signals
  logic [CB-1:0]   base_x, base_y;
  logic            neg_x, neg_y, vert_f, exact_x, exact_y;
  logic [CB+1:0]   px, py;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_distance <= pop_pkg::DIST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      offset_distance <= cfg_data;
    end
  end

  pop_front #(.CB(CB)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .distance  (offset_distance),
    .out_valid (cv[0]),
    .s         (cs[0]),
    .tx        (ctx[0]),
    .ty        (cty[0]),
    .side      (cside[0])
  );

  // partial quotients start empty
  assign cq2x[0] = '0;
  assign cqsx[0] = '0;
  assign cqx[0]  = '0;
  assign cq2y[0] = '0;
  assign cqsy[0] = '0;
  assign cqy[0]  = '0;

  // cell g settles quotient bit QB-1-g, most significant first
  for (genvar g = 0; g < QB; g++) begin : g_cell
    pop_cell #(.CB(CB), .BIT(QB-1-g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[g]),
      .s_in      (cs[g]),
      .tx_in     (ctx[g]),
      .ty_in     (cty[g]),
      .q2sx_in   (cq2x[g]),
      .qsx_in    (cqsx[g]),
      .qx_in     (cqx[g]),
      .q2sy_in   (cq2y[g]),
      .qsy_in    (cqsy[g]),
      .qy_in     (cqy[g]),
      .side_in   (cside[g]),
      .out_valid (cv[g+1]),
      .s_out     (cs[g+1]),
      .tx_out    (ctx[g+1]),
      .ty_out    (cty[g+1]),
      .q2sx_out  (cq2x[g+1]),
      .qsx_out   (cqsx[g+1]),
      .qx_out    (cqx[g+1]),
      .q2sy_out  (cq2y[g+1]),
      .qsy_out   (cqsy[g+1]),
      .qy_out    (cqy[g+1]),
      .side_out  (cside[g+1])
    );
  end

  // unpack the side data at the end of the row
  assign base_x  = cside[QB][CB-1:0];
  assign base_y  = cside[QB][2*CB-1:CB];
  assign neg_y   = cside[QB][2*CB];
  assign neg_x   = cside[QB][2*CB+1];
  assign vert_f  = cside[QB][2*CB+2];
  assign exact_x = (cq2x[QB] == W'(ctx[QB]));
  assign exact_y = (cq2y[QB] == W'(cty[QB]));

  // base plus signed offset, truncated toward zero when inexact
  function automatic logic [CB+1:0] add_trunc(input logic [CB-1:0] base,
                                              input logic [QB-1:0] q,
                                              input logic exact,
                                              input logic neg);
    logic [CB+1:0] b, qq, t;
    b  = {{2{base[CB-1]}}, base};
    qq = (CB+2)'(q);
    if (exact) begin
      t = neg ? (b - qq) : (b + qq);
    end else begin
      t = neg ? (b - qq - (CB+2)'(1)) : (b + qq);
      if (t[CB+1]) begin
        t = t + (CB+2)'(1);
      end
    end
    return t;
  endfunction

  assign px = add_trunc(base_x, cqx[QB], exact_x, neg_x);
  assign py = add_trunc(base_y, cqy[QB], exact_y, neg_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cv[QB];
    end
  end

  always_ff @(posedge clk) begin
    point_x       <= px[CB:0];
    point_y       <= py[CB:0];
    vertical_edge <= vert_f;
  end

  // each result strobe traces back through every cell and the done register to a row entry
  a_done_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cv[0], QB+1))
    else $error("result strobe out of step with the cell row");

  // config write lands in the distance register
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> offset_distance == $past(cfg_data))
    else $error("offset distance not updated");

  // full quotient never exceeds the target square
  a_bound: assert property (@(posedge clk) disable iff (rst)
    cv[QB] |-> (cq2x[QB] <= W'(ctx[QB])) && (cq2y[QB] <= W'(cty[QB])))
    else $error("quotient square overshoots target");
endmodule
`default_nettype wire

### design/pop_front.sv
// front end: edge deltas, magnitudes, squares and scaled targets
`default_nettype none
module pop_front #(
  parameter int CB = pop_pkg::COORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [CB-1:0]        start_x,
  input  wire logic [CB-1:0]        start_y,
  input  wire logic [CB-1:0]        end_x,
  input  wire logic [CB-1:0]        end_y,
  input  wire logic [pop_pkg::DIST_BITS-1:0] distance,
  output logic                      out_valid,
  output logic [2*CB:0]             s,
  output logic [2*CB+2*pop_pkg::DIST_BITS-1:0] tx,
  output logic [2*CB+2*pop_pkg::DIST_BITS-1:0] ty,
  output logic [2*CB+2:0]           side
);
  localparam int DB = pop_pkg::DIST_BITS;
  localparam int DW = CB + DB;

  logic [CB:0]   dx_raw, dy, dx, ax_full, ay_full;
  logic          vert;

  logic          v1, v2;
  logic [CB-1:0] ax1, ay1;
  logic [DB-1:0] d1;
  logic [2*CB+2:0] side1, side2;
  logic [2*CB-1:0] ax2, ay2;
  logic [DW-1:0] dax, day;

  // stage 1 logic: deltas with the vertical repair
  assign dx_raw  = {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
  assign dy      = {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
  assign vert    = (dx_raw == '0);
  assign dx      = vert ? (CB+1)'(1) : dx_raw;
  assign ax_full = dx[CB] ? (~dx + (CB+1)'(1)) : dx;
  assign ay_full = dy[CB] ? (~dy + (CB+1)'(1)) : dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    // side: vert, x offset sign (from dy), y offset sign (from dx), base y, base x
    ax1   <= ax_full[CB-1:0];
    ay1   <= ay_full[CB-1:0];
    d1    <= distance;
    side1 <= {vert, dy[CB], ~dx_raw[CB], start_y, start_x};
    ax2   <= (2*CB)'(ax1) * (2*CB)'(ax1);
    ay2   <= (2*CB)'(ay1) * (2*CB)'(ay1);
    dax   <= DW'(d1) * DW'(ax1);
    day   <= DW'(d1) * DW'(ay1);
    side2 <= side1;
    s     <= (2*CB+1)'(ax2) + (2*CB+1)'(ay2);
    tx    <= (2*DW)'(day) * (2*DW)'(day);
    ty    <= (2*DW)'(dax) * (2*DW)'(dax);
    side  <= side2;
  end
endmodule
`default_nettype wire

### design/pop_cell.sv
// one quotient bit for both coordinates, by incremental square compare
`default_nettype none
module pop_cell #(
  parameter int CB  = pop_pkg::COORD_BITS_DEF,
  parameter int BIT = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [2*CB:0]        s_in,
  input  wire logic [2*CB+2*pop_pkg::DIST_BITS-1:0] tx_in,
  input  wire logic [2*CB+2*pop_pkg::DIST_BITS-1:0] ty_in,
  input  wire logic [2*CB+2*pop_pkg::DIST_BITS:0]   q2sx_in,
  input  wire logic [2*CB+2*pop_pkg::DIST_BITS:0]   qsx_in,
  input  wire logic [pop_pkg::Q_BITS-1:0]           qx_in,
  input  wire logic [2*CB+2*pop_pkg::DIST_BITS:0]   q2sy_in,
  input  wire logic [2*CB+2*pop_pkg::DIST_BITS:0]   qsy_in,
  input  wire logic [pop_pkg::Q_BITS-1:0]           qy_in,
  input  wire logic [2*CB+2:0]      side_in,
  output logic                      out_valid,
  output logic [2*CB:0]             s_out,
  output logic [2*CB+2*pop_pkg::DIST_BITS-1:0] tx_out,
  output logic [2*CB+2*pop_pkg::DIST_BITS-1:0] ty_out,
  output logic [2*CB+2*pop_pkg::DIST_BITS:0]   q2sx_out,
  output logic [2*CB+2*pop_pkg::DIST_BITS:0]   qsx_out,
  output logic [pop_pkg::Q_BITS-1:0]           qx_out,
  output logic [2*CB+2*pop_pkg::DIST_BITS:0]   q2sy_out,
  output logic [2*CB+2*pop_pkg::DIST_BITS:0]   qsy_out,
  output logic [pop_pkg::Q_BITS-1:0]           qy_out,
  output logic [2*CB+2:0]           side_out
);
  localparam int W = 2*CB + 2*pop_pkg::DIST_BITS + 1;

  logic [W-1:0] s_w, cand_x, cand_y;
  logic         take_x, take_y;

  // (q + 2^k)^2 * s = q^2 s + q s 2^(k+1) + s 2^(2k)
  assign s_w    = W'(s_in);
  assign cand_x = q2sx_in + (qsx_in << (BIT+1)) + (s_w << (2*BIT));
  assign cand_y = q2sy_in + (qsy_in << (BIT+1)) + (s_w << (2*BIT));
  assign take_x = (cand_x <= W'(tx_in));
  assign take_y = (cand_y <= W'(ty_in));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s_out    <= s_in;
    tx_out   <= tx_in;
    ty_out   <= ty_in;
    side_out <= side_in;
    q2sx_out <= take_x ? cand_x : q2sx_in;
    qsx_out  <= take_x ? (qsx_in + (s_w << BIT)) : qsx_in;
    qx_out   <= qx_in | (pop_pkg::Q_BITS'(take_x) << BIT);
    q2sy_out <= take_y ? cand_y : q2sy_in;
    qsy_out  <= take_y ? (qsy_in + (s_w << BIT)) : qsy_in;
    qy_out   <= qy_in | (pop_pkg::Q_BITS'(take_y) << BIT);
  end
endmodule
`default_nettype wire

### verif/perpendicular_offset_point_top_tb.sv
// testbench for the perpendicular offset point block: directed and random edges
`timescale 1ns / 1ps
module perpendicular_offset_point_top_tb;
  localparam int CB = pop_pkg::COORD_BITS_DEF;
  localparam int DB = pop_pkg::DIST_BITS;
  localparam int LATENCY = 14;

  typedef struct {
    logic signed [CB:0] px;
    logic signed [CB:0] py;
    logic               vert;
  } offset_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [DB-1:0] cfg_data = '0;
  logic done;
  logic signed [CB:0] point_x, point_y;
  logic vertical_edge;

  // predictor copy of the distance register
  logic [DB-1:0] dist_shadow = pop_pkg::DIST_RESET;
  offset_point_t pending_points[$];
  int fail_count = 0;
  int idle_pct = 0;

  perpendicular_offset_point_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .point_x(point_x), .point_y(point_y),
    .vertical_edge(vertical_edge)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // exact compare of q^2*b^2 against (d^2-q^2)*a^2
  function automatic int trial_cmp(longint unsigned q, longint unsigned d,
                                   longint unsigned a, longint unsigned b);
    logic [127:0] lhs, rhs;
    lhs = 128'(q) * 128'(q) * 128'(b) * 128'(b);
    rhs = (128'(d) * 128'(d) - 128'(q) * 128'(q)) * 128'(a) * 128'(a);
    if (lhs < rhs) return -1;
    if (lhs > rhs) return 1;
    return 0;
  endfunction

  // floor of d*a/sqrt(a^2+b^2), exact flag beside it
  function automatic longint unsigned floor_offset(longint unsigned d,
      longint unsigned a, longint unsigned b, output bit exact);
    longint unsigned q, c;
    q = 0;
    for (int i = 9; i >= 0; i--) begin
      c = q | (64'd1 << i);
      if (c <= d && trial_cmp(c, d, a, b) <= 0) q = c;
    end
    exact = (trial_cmp(q, d, a, b) == 0);
    return q;
  endfunction

  // base plus signed fraction, rounded toward zero
  function automatic longint trunc_add(longint base, longint unsigned q, bit exact, bit neg);
    longint t;
    if (exact) return neg ? base - longint'(q) : base + longint'(q);
    t = base + (neg ? -(longint'(q) + 1) : longint'(q));
    return (t >= 0) ? t : t + 1;
  endfunction

  function automatic offset_point_t predict_point(logic signed [CB-1:0] x1,
      logic signed [CB-1:0] y1, logic signed [CB-1:0] x2, logic signed [CB-1:0] y2);
    offset_point_t r;
    longint dx, dy, px, py;
    longint unsigned ax, ay, qx, qy;
    bit ex, ey;
    dx = longint'(x2) - longint'(x1);
    dy = longint'(y2) - longint'(y1);
    r.vert = (dx == 0);
    if (r.vert) dx = 1;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    qx = floor_offset(dist_shadow, ay, ax, ex);
    qy = floor_offset(dist_shadow, ax, ay, ey);
    px = trunc_add(longint'(x1), qx, ex, dy < 0);
    py = trunc_add(longint'(y1), qy, ey, dx > 0);
    r.px = px[CB:0];
    r.py = py[CB:0];
    return r;
  endfunction

  // send one edge, with random sender idling first; start stays high after
  task automatic send_edge(logic signed [CB-1:0] x1, logic signed [CB-1:0] y1,
                           logic signed [CB-1:0] x2, logic signed [CB-1:0] y2);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    start_x <= x1; start_y <= y1; end_x <= x2; end_y <= y2;
    do @(posedge clk); while (busy);
    pending_points.push_back(predict_point(x1, y1, x2, y2));
  endtask

  // wait for every expected point, then let the pipe drain
  task automatic drain_points();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_points.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // register write only while idle
  task automatic write_distance(logic [DB-1:0] d);
    drain_points();
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dist_shadow = d;
  endtask

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CB'($urandom);
      1: return CB'($urandom_range(2000)) - CB'(1000);
      default: return {1'b0, {(CB-1){1'b1}}} - CB'($urandom_range(50)) ^
                      {CB{$urandom_range(1) == 1}};
    endcase
  endfunction

  // extremes of the fields, vertical and degenerate edges
  task automatic test_directed();
    logic signed [CB-1:0] mx, mn;
    mx = {1'b0, {(CB-1){1'b1}}};
    mn = {1'b1, {(CB-1){1'b0}}};
    idle_pct = 0;
    send_edge(0, 0, 10, 0);
    send_edge(0, 0, 0, 10);       // vertical, upward
    send_edge(0, 0, 0, -10);      // vertical, downward
    send_edge(5, 5, 5, 5);        // zero-length edge
    send_edge(mx, mx, mn, mn);
    send_edge(mn, mn, mx, mx);
    send_edge(mx, mn, mn, mx);
    send_edge(mn, mx, mx, mn);
    send_edge(mx, 0, mx, mn);
    send_edge(mn, 0, mn, mx);
    send_edge(0, 0, 3, 4);        // exact quotient at a distance of 100
    send_edge(0, 0, -3, -4);
    send_edge(100, -100, 101, -100);
    send_edge(-1, -1, 1, 0);
  endtask

  task automatic test_random(int n, int pct);
    logic signed [CB-1:0] x1, y1;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      x1 = rand_coord();
      y1 = rand_coord();
      if ($urandom_range(9) == 0) send_edge(x1, y1, x1, rand_coord());
      else send_edge(x1, y1, rand_coord(), rand_coord());
    end
  endtask

  // compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    offset_point_t e;
    if (!rst && done) begin
      if (pending_points.size() == 0) begin
        $error("point with no expectation waiting");
        fail_count++;
      end else begin
        e = pending_points.pop_front();
        if (point_x !== e.px) begin
          $error("point_x expected %0d actual %0d", e.px, point_x);
          fail_count++;
        end
        if (point_y !== e.py) begin
          $error("point_y expected %0d actual %0d", e.py, point_y);
          fail_count++;
        end
        if (vertical_edge !== e.vert) begin
          $error("vertical_edge expected %0d actual %0d", e.vert, vertical_edge);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();                      // reset distance of 100
    write_distance(1);
    test_directed();
    write_distance(1023);
    test_directed();
    test_random(280, 0);
    write_distance(DB'($urandom_range(1, 1023)));
    test_random(280, 73);
    drain_points();                       // sender holds until all points arrived
    write_distance(DB'($urandom_range(1, 60)));
    test_random(280, 16);
    write_distance(0);                    // zero distance returns the start point
    test_random(30, 30);
    write_distance(DB'($urandom_range(1, 1023)));
    test_random(240, 73);
    drain_points();
    if (fail_count == 0 && pending_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

### sim.f
design/pop_pkg.sv
design/pop_front.sv
design/pop_cell.sv
design/perpendicular_offset_point_top.sv
verif/perpendicular_offset_point_top_tb.sv
